### hdl/abblur_pkg.sv
// Shared types, constants and helper functions of the alpha binomial blur.
// No dependencies; every other file of the block but abblur_ram refers to it by scoped names.
`default_nettype none

package abblur_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 12;   // 255 * 16 fits
  localparam int NUM_W      = 13;   // sum plus half the divisor
  localparam int DIV_W      = 5;    // total weight, 0 .. 16
  localparam int RECIP_W    = 17;
  localparam int RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1;

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic             flush;
  } pix_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             frame_last;
  } res_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  // Border and emit flags that travel with a word down the pipe.
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [2:0] rmask;   // rows above, at, below the output pixel
    logic [2:0] cmask;   // columns left, at, right of the output pixel
  } tap_info_t;

  // [row][column], row 0 oldest line, column 0 oldest sample
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // Weight of the in-bounds taps of a 1-2-1 line.
  function automatic logic [2:0] line_weight(input logic [2:0] m);
    line_weight = {2'b00, m[0]} + {1'b0, m[1], 1'b0} + {2'b00, m[2]};
  endfunction

  // ceil(2^16 / d) for every total weight the kernel can give; exact for
  // numerators below 4096.
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
    unique case (d)
      5'd1:    recip = 17'd65536;
      5'd2:    recip = 17'd32768;
      5'd3:    recip = 17'd21846;
      5'd4:    recip = 17'd16384;
      5'd6:    recip = 17'd10923;
      5'd8:    recip = 17'd8192;
      5'd9:    recip = 17'd7282;
      5'd12:   recip = 17'd5462;
      5'd16:   recip = 17'd4096;
      default: recip = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

### hdl/abblur_if.sv
// Handshake channels of the blur: pixel input, result output, register writes.
// Depends on abblur_pkg for the payload structs.
`default_nettype none

interface abblur_pix_if;
  logic                  valid;
  logic                  ready;
  abblur_pkg::pix_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abblur_res_if;
  logic                  valid;
  logic                  ready;
  abblur_pkg::res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abblur_cfg_if;
  logic                  valid;
  logic                  ready;
  abblur_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/abblur_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module abblur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/abblur_pos.sv
// Raster position tracking: input and output counters, border flags, frame end.
// Depends on abblur_pkg.
`default_nettype none

module abblur_pos #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic [abblur_pkg::WIDTH_W-1:0]    image_width,
  input  wire logic [abblur_pkg::HEIGHT_W-1:0]   image_height,
  output      logic [$clog2(MAX_WIDTH)-1:0]      in_col,
  output      abblur_pkg::tap_info_t             info
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > abblur_pkg::WIDTH_W) ? WW0 : abblur_pkg::WIDTH_W;
  localparam int HW  = abblur_pkg::HEIGHT_W + 1;

  logic [abblur_pkg::HEIGHT_W-1:0] in_row;
  logic [AW-1:0]                   out_col;
  logic [abblur_pkg::HEIGHT_W-1:0] out_row;

  logic [WW-1:0] w_ext, w, ox, ox_inc, in_inc;
  logic [HW-1:0] h, oy, oy_inc;
  logic          in_wrap, out_wrap;

  always_comb begin
    w_ext = WW'(image_width);
    if (image_width == '0) begin
      w = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = w_ext;
    end
    h = (image_height == '0) ? HW'(1) : HW'(image_height);

    ox     = WW'(out_col);
    ox_inc = ox + WW'(1);
    oy     = HW'(out_row);
    oy_inc = oy + HW'(1);
    in_inc = WW'(in_col) + WW'(1);
    in_wrap  = (in_inc >= w);
    out_wrap = (ox_inc >= w);

    info.cmask[0] = (ox != '0) && (ox <= w);
    info.cmask[1] = (ox < w);
    info.cmask[2] = (ox_inc < w);
    info.rmask[0] = (oy != '0) && (oy <= h);
    info.rmask[1] = (oy < h);
    info.rmask[2] = (oy_inc < h);
    info.last     = out_wrap && (oy_inc >= h);
    info.emit     = (in_row > abblur_pkg::HEIGHT_W'(1))
                 || ((in_row == abblur_pkg::HEIGHT_W'(1)) && (in_col != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (info.emit && info.last) begin
        // frame done: restart every count
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + abblur_pkg::HEIGHT_W'(1);
        end else begin
          in_col <= in_inc[AW-1:0];
        end
        if (info.emit) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + abblur_pkg::HEIGHT_W'(1);
          end else begin
            out_col <= ox_inc[AW-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/abblur_win.sv
// Line stores and 3x3 window: read-modify-write of two line RAMs per word,
// with forwarding for back-to-back words on the same column.
// Depends on abblur_pkg and abblur_ram.
`default_nettype none

module abblur_win #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        in_col,
  input  wire logic [abblur_pkg::PIX_W-1:0]        pix,
  input  wire abblur_pkg::tap_info_t               info_in,
  input  wire logic                                s1_move,
  output      logic                                s1_valid,
  output      abblur_pkg::tap_info_t               s1_info,
  output      abblur_pkg::window_t                 window
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [AW-1:0]                s1_col;
  logic [abblur_pkg::PIX_W-1:0] s1_pix;
  logic                         s1_fwd;
  logic [abblur_pkg::PIX_W-1:0] prev_b, prev_pix;
  logic [abblur_pkg::PIX_W-1:0] rd_a, rd_b, eff_a, eff_b;

  // the previous word writes this column at the same edge this one reads it
  assign eff_a = s1_fwd ? prev_b   : rd_a;
  assign eff_b = s1_fwd ? prev_pix : rd_b;

  abblur_ram #(.WIDTH(abblur_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col),
    .wdata (eff_b),
    .re    (accept),
    .raddr (in_col),
    .rdata (rd_a)
  );

  abblur_ram #(.WIDTH(abblur_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (in_col),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      window   <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        for (int r = 0; r < 3; r++) begin
          window[r][0] <= window[r][1];
          window[r][1] <= window[r][2];
        end
        window[0][2] <= eff_a;
        window[1][2] <= eff_b;
        window[2][2] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= in_col;
      s1_pix  <= pix;
      s1_info <= info_in;
      s1_fwd  <= s1_valid && (in_col == s1_col);
    end
    if (s1_move) begin
      prev_b   <= eff_b;
      prev_pix <= s1_pix;
    end
  end

endmodule

`default_nettype wire

### hdl/abblur_arith.sv
// Masked kernel sum, division by total weight, result register.
// Depends on abblur_pkg and the result channel interface.
`default_nettype none

module abblur_arith (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s1_move,
  input  wire abblur_pkg::tap_info_t s1_info,
  input  wire abblur_pkg::window_t   window,
  output      logic                  s2_free,
  abblur_res_if.source               results
);

  localparam int PROD_W = abblur_pkg::NUM_W + abblur_pkg::RECIP_W;

  logic                  s2_valid;
  abblur_pkg::tap_info_t s2_info;

  logic                           s3_valid;
  logic [abblur_pkg::NUM_W-1:0]   s3_num;
  logic [abblur_pkg::DIV_W-1:0]   s3_div;
  logic                           s3_last;

  logic                  out_valid;
  abblur_pkg::res_word_t out_word;

  logic free3, free4;
  logic [9:0]                     hs [3];
  logic [abblur_pkg::PIX_W-1:0]   t0, t1, t2;
  logic [abblur_pkg::SUM_W-1:0]   sum;
  logic [abblur_pkg::DIV_W-1:0]   div;
  logic [abblur_pkg::NUM_W-1:0]   num;
  logic [PROD_W-1:0]              prod;

  assign free4   = !out_valid || results.ready;
  assign free3   = !s3_valid || free4;
  assign s2_free = !s2_valid || free3;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      t0 = s2_info.cmask[0] ? window[r][0] : '0;
      t1 = s2_info.cmask[1] ? window[r][1] : '0;
      t2 = s2_info.cmask[2] ? window[r][2] : '0;
      hs[r] = 10'(t0) + {1'b0, t1, 1'b0} + 10'(t2);
    end
    sum = (s2_info.rmask[0] ? 12'(hs[0]) : '0)
        + (s2_info.rmask[1] ? {1'b0, hs[1], 1'b0} : '0)
        + (s2_info.rmask[2] ? 12'(hs[2]) : '0);
    div = {2'b00, abblur_pkg::line_weight(s2_info.rmask)}
        * {2'b00, abblur_pkg::line_weight(s2_info.cmask)};
    num = abblur_pkg::NUM_W'(sum) + abblur_pkg::NUM_W'(div >> 1);
    prod = {{abblur_pkg::RECIP_W{1'b0}}, s3_num}
         * {{abblur_pkg::NUM_W{1'b0}}, abblur_pkg::recip(s3_div)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid <= s1_move && s1_info.emit;
      end
      if (free3) begin
        s3_valid <= s2_valid;
      end
      if (free4) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_info <= s1_info;
    end
    if (free3) begin
      s3_num  <= num;
      s3_div  <= div;
      s3_last <= s2_info.last;
    end
    if (free4) begin
      out_word.smoothed   <= prod[abblur_pkg::RECIP_SHIFT +: abblur_pkg::PIX_W];
      out_word.frame_last <= s3_last;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_word;

endmodule

`default_nettype wire

### hdl/alpha_binomial_blur_3x3_core.sv
// Top level of the alpha binomial 3x3 blur: registers, position, line stores,
// arithmetic. Depends on abblur_pkg, abblur_if, abblur_pos, abblur_win, abblur_arith.
//
//  channel  | dir | word                      | moves when
//  ---------+-----+---------------------------+---------------------
//  pixels   | in  | alpha[7:0], flush         | valid && ready
//  results  | out | smoothed[7:0], frame_last | valid && ready
//  cfg      | in  | index[1:0], value[12:0]   | valid && ready
//
// One pixel word per clock while results are taken; line stores are read at accept
// and written back as the word leaves the first stage, so the RAM read latency sets
// the first stage. A result passes the window, sum and divide stages to the result
// register after the word that completes its window is accepted. A frame yields
// results for image_width + 1 words late; send that many flush words after it.
// Reset clears counters, window and pipe valids; the line stores stay as
// they are, since no entry is weighted before it has been written.
// A stalled result register backs up stage by stage; pixels stay accepted
// until every stage holds a word. cfg is always ready.
`default_nettype none

module alpha_binomial_blur_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic   clk,
  input  wire logic   rst,
  abblur_pix_if.sink  pixels,
  abblur_res_if.source results,
  abblur_cfg_if.sink  cfg
);

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [abblur_pkg::WIDTH_W-1:0]  image_width;
  logic [abblur_pkg::HEIGHT_W-1:0] image_height;

  logic                         accept;
  logic                         s1_move;
  logic                         s1_valid;
  logic                         s2_free;
  logic [AW-1:0]                in_col;
  logic [abblur_pkg::PIX_W-1:0] pix;
  abblur_pkg::tap_info_t        info;
  abblur_pkg::tap_info_t        s1_info;
  abblur_pkg::window_t          window;

  assign cfg.ready = 1'b1;

  // take register writes at any time; host keeps them to idle gaps
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= abblur_pkg::WIDTH_RESET;
      image_height <= abblur_pkg::HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        abblur_pkg::REG_IMAGE_WIDTH:
          image_width <= cfg.data.value[abblur_pkg::WIDTH_W-1:0];
        abblur_pkg::REG_IMAGE_HEIGHT:
          image_height <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // the first stage takes a word whenever it is empty or hands its word on
  assign pixels.ready = !s1_valid || s2_free;
  assign accept       = pixels.valid && pixels.ready;
  assign s1_move      = s1_valid && s2_free;

  // invert alpha; a drain word carries zero
  assign pix = pixels.data.flush ? '0 : ~pixels.data.alpha;

  abblur_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .image_width  (image_width),
    .image_height (image_height),
    .in_col       (in_col),
    .info         (info)
  );

  abblur_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_col   (in_col),
    .pix      (pix),
    .info_in  (info),
    .s1_move  (s1_move),
    .s1_valid (s1_valid),
    .s1_info  (s1_info),
    .window   (window)
  );

  abblur_arith u_arith (
    .clk     (clk),
    .rst     (rst),
    .s1_move (s1_move),
    .s1_info (s1_info),
    .window  (window),
    .s2_free (s2_free),
    .results (results)
  );

  // a word that will produce a result sits in the first stage next cycle
  a_emit_enters: assert property (@(posedge clk) disable iff (rst)
    accept && info.emit |=> s1_valid && s1_info.emit)
    else $error("emitting word lost at window stage");

  // a blocked first stage keeps its word and flags
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid && $stable(s1_info))
    else $error("window stage word changed while blocked");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result shown right after reset");

endmodule

`default_nettype wire
